[hw/rtl/digital_bit_slice_agc_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bit-slice AGC
// Concurrent checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DIGITAL_BIT_SLICE_AGC_UNIT_ASSERT_SVH
`define DIGITAL_BIT_SLICE_AGC_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DBSAGC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define DBSAGC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define DBSAGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define DBSAGC_ASSERT_ALWAYS(lbl, expr, msg)
`define DBSAGC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define DBSAGC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/dbsagc_pkg.sv]
// ----------------------------------------------------------------------------
// Bit-slice AGC package
// Shared widths, register indexes, channel pair table and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package dbsagc_pkg;

  localparam int N_DIRECT = 4;
  localparam int N_CROSS  = 12;
  localparam int N_SLOTS  = 16;
  localparam int SLICE_W  = 5;
  localparam int LZ_W     = 6;
  localparam int TGT_W    = 6;

  localparam logic [SLICE_W-1:0] SLICE_MAX = 5'h1F;

  localparam int IN_W  = N_DIRECT * LZ_W;                       // 24
  localparam int RES_W = 1 + N_DIRECT + N_DIRECT * SLICE_W + N_CROSS * SLICE_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;                 // 88

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = N_CROSS * SLICE_W;                // 60

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_MASK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_KEEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_DIRECT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL_CROSS  = 2'd3;

  typedef logic [SLICE_W-1:0] slice_t;

  typedef struct packed {
    logic   adjust;
    slice_t slice;
  } chan_res_t;

  // channel pairs feeding cross slot pairs
  function automatic logic [1:0] pair_lo(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_hi(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dbsagc_chan.sv]
// ----------------------------------------------------------------------------
// Bit-slice AGC direct channel
// Compares kept bits against the target and grows or shrinks one slice.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsagc_chan #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                             is_auto,
  input  wire logic [dbsagc_pkg::LZ_W-1:0]      lead_zeros,
  input  wire logic [dbsagc_pkg::TGT_W-1:0]     target,
  input  wire dbsagc_pkg::slice_t               cur,
  output dbsagc_pkg::chan_res_t                 res
);

  localparam int KW = $clog2(ACC_WIDTH + 1);
  localparam int AW = ((KW > 6) ? KW : 6) + 2;

  logic [AW-1:0] lz_x;
  logic [AW-1:0] lz_c;
  logic [AW-1:0] keep;
  logic [AW-1:0] t_x;
  logic [AW-1:0] cur_x;
  logic [AW-1:0] grow_sum;
  logic [AW-1:0] gap;
  logic          grow;
  logic          shrink;

  always_comb begin
    lz_x     = AW'(lead_zeros);
    lz_c     = (lz_x > AW'(ACC_WIDTH)) ? AW'(ACC_WIDTH) : lz_x;
    keep     = AW'(ACC_WIDTH) - lz_c;
    t_x      = AW'(target);
    cur_x    = AW'(cur);
    grow     = (keep > t_x + AW'(1)) && (cur != dbsagc_pkg::SLICE_MAX);
    shrink   = (t_x != '0) && (keep < t_x - AW'(1));
    grow_sum = cur_x + keep - t_x;
    gap      = t_x - keep;

    res.adjust = 1'b0;
    res.slice  = cur;
    if (is_auto) begin
      if (grow) begin
        res.adjust = 1'b1;
        res.slice  = (grow_sum > AW'(dbsagc_pkg::SLICE_MAX)) ? dbsagc_pkg::SLICE_MAX
                                                              : grow_sum[4:0];
      end else if (shrink) begin
        res.adjust = 1'b1;
        res.slice  = (gap >= cur_x) ? '0 : cur - gap[4:0];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/digital_bit_slice_agc_unit.sv]
// Flow: an input word is taken into the input register (s1_lz); m_tvalid
//   rises when that word advances into the result register (m_tdata).
// Throughput: one word per cycle unless m_tready stalls; the slice update is
//   a single pass of compare/adjust logic between input and result registers.
// Reset (rst, synchronous): clears all slice stores, valid flags, and loads
//   auto_mask = 0xFFFF, target_keep_bits = 16, manual slices = 0.
// ----------------------------------------------------------------------------
// Bit-slice AGC unit
// Adjusts four direct slices from leading-zero counts and derives twelve
// cross slices from channel pairs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digital_bit_slice_agc_unit_assert.svh"

module digital_bit_slice_agc_unit #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // lead_zeros_a, lead_zeros_b, lead_zeros_c, lead_zeros_d
  input  wire logic [dbsagc_pkg::IN_W-1:0]           s_tdata,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // slices_changed, action_flags, direct_slice_word, cross_slice_word, pad
  output logic [dbsagc_pkg::OUT_W-1:0]               m_tdata,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  input  wire logic                                  cfg_we,
  input  wire logic [dbsagc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dbsagc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NS = dbsagc_pkg::SLICE_W;

  logic [dbsagc_pkg::N_SLOTS-1:0]            auto_mask;
  logic [dbsagc_pkg::TGT_W-1:0]              target_keep_bits;
  logic [dbsagc_pkg::N_DIRECT*NS-1:0]        manual_direct_slices;
  logic [dbsagc_pkg::N_CROSS*NS-1:0]         manual_cross_slices;

  dbsagc_pkg::slice_t [dbsagc_pkg::N_DIRECT-1:0] direct_store;
  dbsagc_pkg::slice_t [dbsagc_pkg::N_CROSS-1:0]  cross_store;
  dbsagc_pkg::slice_t [dbsagc_pkg::N_DIRECT-1:0] direct_next;
  dbsagc_pkg::slice_t [dbsagc_pkg::N_CROSS-1:0]  cross_next;
  dbsagc_pkg::slice_t [dbsagc_pkg::N_DIRECT-1:0] direct_eff;
  dbsagc_pkg::slice_t [dbsagc_pkg::N_CROSS-1:0]  cross_eff;

  logic                                          s1_valid;
  logic [dbsagc_pkg::N_DIRECT-1:0][dbsagc_pkg::LZ_W-1:0] s1_lz;
  logic                                          advance;

  dbsagc_pkg::chan_res_t [dbsagc_pkg::N_DIRECT-1:0] chan_res;
  logic [dbsagc_pkg::N_DIRECT-1:0]               flags;
  logic                                          any_change;
  logic [dbsagc_pkg::OUT_W-1:0]                  out_word;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mask            <= '1;
      target_keep_bits     <= dbsagc_pkg::TGT_W'(16);
      manual_direct_slices <= '0;
      manual_cross_slices  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbsagc_pkg::REG_AUTO_MASK:     auto_mask <= cfg_data[dbsagc_pkg::N_SLOTS-1:0];
        dbsagc_pkg::REG_TARGET_KEEP:   target_keep_bits <= cfg_data[dbsagc_pkg::TGT_W-1:0];
        dbsagc_pkg::REG_MANUAL_DIRECT:
          manual_direct_slices <= cfg_data[dbsagc_pkg::N_DIRECT*NS-1:0];
        dbsagc_pkg::REG_MANUAL_CROSS:  manual_cross_slices <= cfg_data;
      endcase
    end
  end

  // per-channel adjust
  for (genvar i = 0; i < dbsagc_pkg::N_DIRECT; i++) begin : g_chan
    dbsagc_chan #(
      .ACC_WIDTH (ACC_WIDTH)
    ) u_chan (
      .is_auto    (auto_mask[i]),
      .lead_zeros (s1_lz[i]),
      .target     (target_keep_bits),
      .cur        (direct_store[i]),
      .res        (chan_res[i])
    );
    assign flags[i]       = chan_res[i].adjust;
    assign direct_next[i] = chan_res[i].slice;
    assign direct_eff[i]  = auto_mask[i] ? chan_res[i].slice
                                         : manual_direct_slices[i*NS +: NS];
  end

  assign any_change = |flags;

  // cross slots from halved pair sums, less one
  always_comb begin
    logic [2:0]         p;
    logic [NS:0]        sum;
    dbsagc_pkg::slice_t half;
    dbsagc_pkg::slice_t v;
    for (int k = 0; k < dbsagc_pkg::N_CROSS; k++) begin
      p    = 3'(k >> 1);
      sum  = {1'b0, direct_eff[dbsagc_pkg::pair_lo(p)]}
           + {1'b0, direct_eff[dbsagc_pkg::pair_hi(p)]};
      half = sum[NS:1];
      v    = (half == '0) ? '0 : half - NS'(1);
      cross_next[k] = (any_change && auto_mask[k + dbsagc_pkg::N_DIRECT]) ? v
                                                                          : cross_store[k];
      cross_eff[k]  = auto_mask[k + dbsagc_pkg::N_DIRECT] ? cross_next[k]
                                                          : manual_cross_slices[k*NS +: NS];
    end
  end

  assign out_word = dbsagc_pkg::OUT_W'({cross_eff, direct_eff, flags, any_change});

  // pipeline control and slice state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      direct_store <= '0;
      cross_store  <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid     <= 1'b1;
        direct_store <= direct_next;
        cross_store  <= cross_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_lz <= s_tdata;
    end
    if (advance) begin
      m_tdata <= out_word;
    end
  end

  `DBSAGC_ASSERT_IMPLIES(a_no_bubble, s1_valid && !m_tvalid, advance, "held word not advanced")
  `DBSAGC_ASSERT_NEXT(a_cross_hold, !(advance && any_change), $stable(cross_store), "cross hold")
  `DBSAGC_ASSERT_NEXT(a_direct_hold, !advance, $stable(direct_store), "direct slice moved")
  `DBSAGC_ASSERT_IMPLIES(a_manual_flag, m_tvalid, ~|(m_tdata[4:1] & ~auto_mask[3:0]), "flag set")

endmodule

`default_nettype wire
